/* rtl/core/psrf_pkg.sv */
// ----------------------------------------------------------------------------
// psrf_pkg
// Types and constants shared by the parameter subscription repeat filter.
// ----------------------------------------------------------------------------
package psrf_pkg;

   localparam int TABLE_SLOTS   = 16;
   localparam int MAX_CHANNELS  = 4;
   localparam int CACHE_DEPTH   = TABLE_SLOTS * MAX_CHANNELS;
   localparam int SLOT_W        = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int CACHE_AW      = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
   localparam int CH_W          = $clog2(MAX_CHANNELS + 1);
   localparam int ID_W          = 11;
   localparam int MSG_W         = 64;
   localparam int TIME_W        = 64;
   localparam int ROW_W         = MSG_W + TIME_W;
   localparam int TIMEOUT_W     = 32;

   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 32'd30_000_000;

   typedef enum logic [1:0] {
      OP_SUBSCRIBE   = 2'd0,
      OP_UNSUBSCRIBE = 2'd1,
      OP_RECEIVE     = 2'd2,
      OP_READ        = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_EXISTS      = 3'd1,
      ST_NO_ENTRY    = 3'd2,
      ST_BAD_CHANNEL = 3'd3,
      ST_FULL        = 3'd4,
      ST_REPEAT      = 3'd5
   } status_type;

   typedef struct packed {
      op_type            operation;
      logic [ID_W-1:0]   param_id;
      logic [7:0]        channel;
      logic [7:0]        channel_count;
      logic [7:0]        sender_node;
      logic [7:0]        data_type;
      logic [7:0]        service_byte;
      logic [7:0]        seq_code;
      logic [31:0]       payload;
      logic [63:0]       now_usec;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic              deliver;
      logic [ID_W-1:0]   out_param_id;
      logic [7:0]        out_channel;
      logic [7:0]        out_node;
      logic [7:0]        out_type;
      logic [7:0]        out_service;
      logic [7:0]        out_code;
      logic [31:0]       out_payload;
      logic [63:0]       out_time;
   } rsp_type;

endpackage

/* rtl/core/param_subscription_repeat_filter.sv */
// ----------------------------------------------------------------------------
// param_subscription_repeat_filter
// Subscription table for redundant parameter messages with a per-channel
// last-message cache that drops repeated messages.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries one operation word: subscribe, unsubscribe, receive
//   or read cache. rsp channel returns exactly one result word per request.
//   csr_wr_en/csr_wr_data write the repeat timeout; write it only while idle.
// Path: a word accepted on req passes through the lookup stage, then the
//   result register, whose output drives rsp.
// Throughput: one word per cycle while rsp_stall stays low. The cache RAM
//   read-modify-write keeps pace: the read is issued at accept, the write in
//   the lookup stage, with a forwarding register between back-to-back words.
// Reset: table empty, all cache rows read as zero, timeout back to
//   30 000 000 us. No clearing pass; the block accepts from the first cycle.
// Stall: while rsp_stall is high the result word holds; one more word may
//   sit in the lookup stage, after which req_stall rises.
// ----------------------------------------------------------------------------
module param_subscription_repeat_filter (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  psrf_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output psrf_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic [31:0]       csr_wr_data
);
   import psrf_pkg::*;

   logic                 req_accept;
   logic                 s1_advance;

   req_type              s1_req_ff;
   logic                 s1_vld_ff;
   rsp_type              rsp_ff;
   rsp_type              rsp_in;
   logic                 rsp_vld_ff;
   logic [TIMEOUT_W-1:0] timeout_ff;

   logic [TABLE_SLOTS-1:0] entry_vld_ff;
   logic [TABLE_SLOTS-1:0] entry_vld_in;
   logic [ID_W-1:0]        entry_id_ff [TABLE_SLOTS];
   logic [CH_W-1:0]        entry_ch_ff [TABLE_SLOTS];
   logic [CACHE_DEPTH-1:0] cache_vld_ff;
   logic [CACHE_DEPTH-1:0] cache_vld_in;

   logic                 fwd_hit_ff;
   logic [ROW_W-1:0]     fwd_data_ff;

   logic                 ram_wr_en;
   logic [CACHE_AW-1:0]  ram_wr_addr;
   logic [ROW_W-1:0]     ram_wr_data;
   logic [CACHE_AW-1:0]  ram_rd_addr;
   logic [ROW_W-1:0]     ram_rd_data;

   logic [SLOT_W-1:0]    slot_a;
   logic [7:0]           ch_a;

   logic                 hit_b;
   logic [SLOT_W-1:0]    slot_b;
   logic                 free_found;
   logic [SLOT_W-1:0]    free_slot;
   logic                 sub_ok;
   logic [CACHE_AW-1:0]  cache_idx;
   logic [ROW_W-1:0]     cache_row;
   logic [63:0]          old_time;
   logic [7:0]           old_code;
   logic [63:0]          time_gap;
   logic signed [8:0]    code_diff;
   logic                 code_ahead;
   logic                 rx_ok;

   assign req_accept = req_valid && !req_stall;
   assign s1_advance = s1_vld_ff && (!rsp_vld_ff || !rsp_stall);
   assign req_stall  = s1_vld_ff && !s1_advance;

   // lookup for the read address at accept; the lookup stage re-checks
   always_comb begin
      slot_a = '0;
      for (int s = 0; s < TABLE_SLOTS; s++) begin
         if (entry_vld_ff[s] && entry_id_ff[s] == req_data.param_id) begin
            slot_a = SLOT_W'(s);
         end
      end
      ch_a = (req_data.channel < 8'(MAX_CHANNELS)) ? req_data.channel : 8'd0;
      ram_rd_addr = CACHE_AW'(slot_a) * CACHE_AW'(MAX_CHANNELS) + CACHE_AW'(ch_a);
   end

   psrf_ram #(
      .WIDTH (ROW_W),
      .DEPTH (CACHE_DEPTH)
   ) u_cache (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (req_accept),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // lookup stage
   always_comb begin
      hit_b      = 1'b0;
      slot_b     = '0;
      free_found = 1'b0;
      free_slot  = '0;
      for (int s = 0; s < TABLE_SLOTS; s++) begin
         if (entry_vld_ff[s] && entry_id_ff[s] == s1_req_ff.param_id) begin
            hit_b  = 1'b1;
            slot_b = SLOT_W'(s);
         end
      end
      // lowest free slot wins
      for (int s = TABLE_SLOTS - 1; s >= 0; s--) begin
         if (!entry_vld_ff[s]) begin
            free_found = 1'b1;
            free_slot  = SLOT_W'(s);
         end
      end
   end

   always_comb begin
      cache_idx = CACHE_AW'(slot_b) * CACHE_AW'(MAX_CHANNELS)
                + CACHE_AW'(s1_req_ff.channel);
      // a row not written since its subscribe reads as zero
      if (cache_vld_ff[cache_idx]) begin
         cache_row = fwd_hit_ff ? fwd_data_ff : ram_rd_data;
      end else begin
         cache_row = '0;
      end
      old_time   = cache_row[ROW_W-1:MSG_W];
      old_code   = cache_row[39:32];
      time_gap   = s1_req_ff.now_usec - old_time;
      code_diff  = $signed({1'b0, s1_req_ff.seq_code}) - $signed({1'b0, old_code});
      code_ahead = (code_diff >= 9'sd1 && code_diff <= 9'sd126) || (code_diff <= -9'sd128);
   end

   always_comb begin
      rsp_in                = '0;
      rsp_in.status         = ST_OK;
      rsp_in.out_param_id   = s1_req_ff.param_id;
      rsp_in.out_channel    = s1_req_ff.channel;
      entry_vld_in          = entry_vld_ff;
      cache_vld_in          = cache_vld_ff;
      sub_ok                = 1'b0;
      rx_ok                 = 1'b0;

      unique case (s1_req_ff.operation)
         OP_SUBSCRIBE: begin
            if (s1_req_ff.channel_count == 8'd0 ||
                s1_req_ff.channel_count > 8'(MAX_CHANNELS)) begin
               rsp_in.status = ST_BAD_CHANNEL;
            end else if (hit_b) begin
               rsp_in.status = ST_EXISTS;
            end else if (!free_found) begin
               rsp_in.status = ST_FULL;
            end else begin
               sub_ok                  = 1'b1;
               entry_vld_in[free_slot] = 1'b1;
               for (int i = 0; i < MAX_CHANNELS; i++) begin
                  cache_vld_in[CACHE_AW'(free_slot) * CACHE_AW'(MAX_CHANNELS)
                               + CACHE_AW'(i)] = 1'b0;
               end
            end
         end
         OP_UNSUBSCRIBE: begin
            if (!hit_b) begin
               rsp_in.status = ST_NO_ENTRY;
            end else begin
               entry_vld_in[slot_b] = 1'b0;
            end
         end
         OP_RECEIVE, OP_READ: begin
            if (!hit_b) begin
               rsp_in.status = ST_NO_ENTRY;
            end else if (s1_req_ff.channel >= 8'(entry_ch_ff[slot_b]) ||
                         s1_req_ff.channel >= 8'(MAX_CHANNELS)) begin
               rsp_in.status = ST_BAD_CHANNEL;
            end else if (s1_req_ff.operation == OP_RECEIVE) begin
               if (old_time != 64'd0 &&
                   time_gap < {32'd0, timeout_ff} && !code_ahead) begin
                  rsp_in.status = ST_REPEAT;
               end else begin
                  rx_ok                   = 1'b1;
                  cache_vld_in[cache_idx] = 1'b1;
                  rsp_in.deliver          = 1'b1;
                  rsp_in.out_node         = s1_req_ff.sender_node;
                  rsp_in.out_type         = s1_req_ff.data_type;
                  rsp_in.out_service      = s1_req_ff.service_byte;
                  rsp_in.out_code         = s1_req_ff.seq_code;
                  rsp_in.out_payload      = s1_req_ff.payload;
                  rsp_in.out_time         = s1_req_ff.now_usec;
               end
            end else begin
               rsp_in.out_node    = cache_row[63:56];
               rsp_in.out_type    = cache_row[55:48];
               rsp_in.out_service = cache_row[47:40];
               rsp_in.out_code    = cache_row[39:32];
               rsp_in.out_payload = cache_row[31:0];
               rsp_in.out_time    = old_time;
            end
         end
         default: begin
            rsp_in.status = ST_OK;
         end
      endcase
   end

   assign ram_wr_en   = s1_advance && rx_ok;
   assign ram_wr_addr = cache_idx;
   assign ram_wr_data = {s1_req_ff.now_usec, s1_req_ff.sender_node, s1_req_ff.data_type,
                         s1_req_ff.service_byte, s1_req_ff.seq_code,
                         s1_req_ff.payload};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff    <= 1'b0;
         rsp_vld_ff   <= 1'b0;
         timeout_ff   <= TIMEOUT_RESET;
         entry_vld_ff <= '0;
         cache_vld_ff <= '0;
         fwd_hit_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            timeout_ff <= csr_wr_data;
         end
         if (req_accept) begin
            s1_vld_ff <= 1'b1;
            // same row written by the word leaving the lookup stage
            fwd_hit_ff <= ram_wr_en && (ram_wr_addr == ram_rd_addr);
         end else if (s1_advance) begin
            s1_vld_ff <= 1'b0;
         end
         if (s1_advance) begin
            rsp_vld_ff   <= 1'b1;
            entry_vld_ff <= entry_vld_in;
            cache_vld_ff <= cache_vld_in;
         end else if (!rsp_stall) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_req_ff   <= req_data;
         fwd_data_ff <= ram_wr_data;
      end
      if (s1_advance) begin
         rsp_ff <= rsp_in;
      end
      if (s1_advance && sub_ok) begin
         entry_id_ff[free_slot] <= s1_req_ff.param_id;
         entry_ch_ff[free_slot] <= CH_W'(s1_req_ff.channel_count);
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTH
   a_deliver_ok : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_data.deliver || rsp_data.status == ST_OK))
      else $error("deliver raised with a non-ok status");

   a_stall_full : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_vld_ff && rsp_vld_ff && rsp_stall))
      else $error("request stalled with room in the pipeline");

   a_sub_entry : assert property (@(posedge clock) disable iff (reset)
      (s1_advance && sub_ok) |=> entry_vld_ff[$past(free_slot)])
      else $error("subscribed slot not marked valid");

   a_rx_row : assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |=> cache_vld_ff[$past(cache_idx)])
      else $error("written cache row not marked valid");
`endif

endmodule

/* rtl/core/psrf_ram.sv */
// ----------------------------------------------------------------------------
// psrf_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module psrf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* test/param_subscription_repeat_filter_test.sv */
// ----------------------------------------------------------------------------
// param_subscription_repeat_filter_test
// Self-checking bench for the subscription table and its per-channel repeat
// filter. A short directed table covers all status codes but ST_FULL, the
// code-ahead limits and the timeout edge. Random operation words follow under
// six repeat timeouts and three idling mixes. Each result word is checked
// field by field: typed rows by their result, others by the table/cache model.
// ----------------------------------------------------------------------------
module param_subscription_repeat_filter_test;
   timeunit 1ns;
   timeprecision 1ps;

   import psrf_pkg::*;

   localparam int ID_POOL    = 22;
   localparam int PHASES     = 6;
   localparam int PHASE_SIZE = 230;
   localparam int MAX_REPORTS = 100;

   typedef struct {
      req_type word;
      bit      typed;
      rsp_type result;
   } dir_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic    csr_wr_en = 1'b0;
   logic [31:0] csr_wr_data = '0;

   // model of the table and caches
   bit          slot_used [TABLE_SLOTS];
   logic [ID_W-1:0] slot_id [TABLE_SLOTS];
   int          slot_chans [TABLE_SLOTS];
   logic [63:0] cached_stamp [CACHE_DEPTH];
   logic [63:0] cached_word [CACHE_DEPTH];
   logic [31:0] repeat_window = TIMEOUT_RESET;

   rsp_type     pending_results [$];
   dir_row_type dir_rows [$];
   logic [ID_W-1:0] id_pool [ID_POOL];
   logic [63:0] stamp;
   logic [31:0] timeout_plan [PHASES];
   int          idle_pct = 0;
   int          stall_pct = 0;
   int          fail_count = 0;
   int          words_sent = 0;
   int          results_checked = 0;
   int          delivered_seen = 0;
   int          repeats_seen = 0;
   int          full_seen = 0;

   param_subscription_repeat_filter uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   function automatic int find_slot(logic [ID_W-1:0] id);
      int found;
      found = -1;
      for (int s = TABLE_SLOTS - 1; s >= 0; s--)
         if (slot_used[s] && slot_id[s] == id) found = s;
      return found;
   endfunction

   function automatic bit code_ahead(logic [7:0] fresh, logic [7:0] old);
      int d;
      d = int'(fresh) - int'(old);
      return (d >= 1 && d <= 126) || d <= -128;
   endfunction

   function automatic rsp_type with_message(rsp_type r, logic [63:0] word,
                                            logic [63:0] t);
      rsp_type o;
      o = r;
      o.out_node    = word[63:56];
      o.out_type    = word[55:48];
      o.out_service = word[47:40];
      o.out_code    = word[39:32];
      o.out_payload = word[31:0];
      o.out_time    = t;
      return o;
   endfunction

   // applies one word to the model and returns the result it should give
   function automatic rsp_type predict_filter_result(req_type w);
      rsp_type     r;
      int          slot;
      int          free_slot;
      int          row_ix;
      logic [63:0] msg_word;
      logic [63:0] age;
      r = '0;
      r.status = ST_OK;
      r.out_param_id = w.param_id;
      r.out_channel = w.channel;
      slot = find_slot(w.param_id);
      msg_word = {w.sender_node, w.data_type, w.service_byte, w.seq_code, w.payload};
      if (w.operation == OP_SUBSCRIBE) begin
         free_slot = -1;
         for (int s = TABLE_SLOTS - 1; s >= 0; s--)
            if (!slot_used[s]) free_slot = s;
         if (w.channel_count == 0 || w.channel_count > MAX_CHANNELS) begin
            r.status = ST_BAD_CHANNEL;
         end else if (slot >= 0) begin
            r.status = ST_EXISTS;
         end else if (free_slot < 0) begin
            r.status = ST_FULL;
         end else begin
            slot_used[free_slot] = 1'b1;
            slot_id[free_slot] = w.param_id;
            slot_chans[free_slot] = int'(w.channel_count);
            for (int c = 0; c < MAX_CHANNELS; c++) begin
               cached_stamp[free_slot * MAX_CHANNELS + c] = '0;
               cached_word[free_slot * MAX_CHANNELS + c] = '0;
            end
         end
      end else if (w.operation == OP_UNSUBSCRIBE) begin
         if (slot < 0) r.status = ST_NO_ENTRY;
         else slot_used[slot] = 1'b0;
      end else if (slot < 0) begin
         r.status = ST_NO_ENTRY;
      end else if (w.channel >= slot_chans[slot] || w.channel >= MAX_CHANNELS) begin
         r.status = ST_BAD_CHANNEL;
      end else begin
         row_ix = slot * MAX_CHANNELS + int'(w.channel);
         if (w.operation == OP_RECEIVE) begin
            age = w.now_usec - cached_stamp[row_ix];
            if (cached_stamp[row_ix] != 0 && age < {32'd0, repeat_window} &&
                !code_ahead(w.seq_code, cached_word[row_ix][39:32])) begin
               r.status = ST_REPEAT;
            end else begin
               cached_word[row_ix] = msg_word;
               cached_stamp[row_ix] = w.now_usec;
               r.deliver = 1'b1;
               r = with_message(r, msg_word, w.now_usec);
            end
         end else begin
            r = with_message(r, cached_word[row_ix], cached_stamp[row_ix]);
         end
      end
      return r;
   endfunction

   function automatic void add_row(op_type op, int id, int ch, int count, int code,
                                   logic [31:0] pay, logic [63:0] now, bit typed,
                                   status_type st);
      dir_row_type row;
      row.word = '0;
      row.word.operation = op;
      row.word.param_id = ID_W'(id);
      row.word.channel = 8'(ch);
      row.word.channel_count = 8'(count);
      row.word.sender_node = pay[7:0];
      row.word.data_type = pay[15:8];
      row.word.service_byte = pay[23:16];
      row.word.seq_code = 8'(code);
      row.word.payload = pay;
      row.word.now_usec = now;
      row.typed = typed;
      row.result = '0;
      row.result.status = st;
      row.result.out_param_id = ID_W'(id);
      row.result.out_channel = 8'(ch);
      dir_rows.push_back(row);
   endfunction

   // mostly traffic on a small id pool so the table fills and caches repeat
   function automatic req_type random_word();
      req_type    w;
      int         pick;
      int         slot;
      logic [7:0] old_code;
      w.sender_node = 8'($urandom);
      w.data_type = 8'($urandom);
      w.service_byte = 8'($urandom);
      w.payload = $urandom;
      w.param_id = ($urandom_range(99) < 92) ? id_pool[$urandom_range(ID_POOL - 1)]
                                              : ID_W'($urandom);
      pick = $urandom_range(99);
      if (pick < 14) w.operation = OP_SUBSCRIBE;
      else if (pick < 22) w.operation = OP_UNSUBSCRIBE;
      else if (pick < 82) w.operation = OP_RECEIVE;
      else w.operation = OP_READ;
      w.channel_count = ($urandom_range(99) < 85) ? 8'($urandom_range(1, MAX_CHANNELS))
                                                   : 8'($urandom_range(0, 255));
      pick = $urandom_range(99);
      if (pick < 85) w.channel = 8'($urandom_range(0, MAX_CHANNELS - 1));
      else if (pick < 95) w.channel = 8'($urandom_range(0, 7));
      else w.channel = 8'($urandom_range(0, 255));
      slot = find_slot(w.param_id);
      if (slot >= 0 && w.channel < MAX_CHANNELS)
         old_code = cached_word[slot * MAX_CHANNELS + int'(w.channel)][39:32];
      else
         old_code = 8'($urandom);
      // codes around the ahead/behind limits of the cached one
      case ($urandom_range(7))
         0: w.seq_code = old_code;
         1: w.seq_code = old_code + 8'd1;
         2: w.seq_code = old_code + 8'd126;
         3: w.seq_code = old_code + 8'd127;
         4: w.seq_code = old_code + 8'd128;
         5: w.seq_code = old_code - 8'd1;
         6: w.seq_code = old_code + 8'($urandom_range(2, 125));
         default: w.seq_code = 8'($urandom);
      endcase
      pick = $urandom_range(99);
      if (pick < 3) begin
         w.now_usec = '0;
      end else if (pick < 6) begin
         w.now_usec = stamp - 64'($urandom_range(1, 1000));
      end else if (pick < 8) begin
         w.now_usec = {$urandom, $urandom};
      end else begin
         if (pick < 13) stamp = stamp + 64'($urandom);
         else stamp = stamp + 64'($urandom_range(0, 300));
         w.now_usec = stamp;
      end
      return w;
   endfunction

   task automatic send_word(req_type w, bit typed, rsp_type typed_result);
      rsp_type predicted;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      predicted = predict_filter_result(w);
      pending_results.push_back(typed ? typed_result : predicted);
      words_sent++;
   endtask

   task automatic write_timeout(logic [31:0] value);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      repeat_window = value;
   endtask

   function automatic void compare_field(string name, logic [63:0] want,
                                         logic [63:0] got);
      if (want !== got) begin
         fail_count++;
         if (fail_count <= MAX_REPORTS)
            $error("%s: expected %0h, actual %0h", name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_results.size() == 0) begin
            fail_count++;
            $error("result word with nothing pending: %0h", rsp_data);
         end else begin
            want = pending_results.pop_front();
            compare_field("status", want.status, rsp_data.status);
            compare_field("deliver", want.deliver, rsp_data.deliver);
            compare_field("out_param_id", want.out_param_id, rsp_data.out_param_id);
            compare_field("out_channel", want.out_channel, rsp_data.out_channel);
            compare_field("out_node", want.out_node, rsp_data.out_node);
            compare_field("out_type", want.out_type, rsp_data.out_type);
            compare_field("out_service", want.out_service, rsp_data.out_service);
            compare_field("out_code", want.out_code, rsp_data.out_code);
            compare_field("out_payload", want.out_payload, rsp_data.out_payload);
            compare_field("out_time", want.out_time, rsp_data.out_time);
            results_checked++;
            if (want.deliver) delivered_seen++;
            if (want.status == ST_REPEAT) repeats_seen++;
            if (want.status == ST_FULL) full_seen++;
         end
      end
   end

   initial begin
      #3_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      for (int s = 0; s < TABLE_SLOTS; s++) begin
         slot_used[s] = 1'b0;
         slot_id[s] = '0;
         slot_chans[s] = 0;
      end
      for (int c = 0; c < CACHE_DEPTH; c++) begin
         cached_stamp[c] = '0;
         cached_word[c] = '0;
      end
      id_pool[0] = '0;
      id_pool[1] = '1;
      for (int i = 2; i < ID_POOL; i++) id_pool[i] = ID_W'($urandom);
      stamp = {32'd0, $urandom};
      timeout_plan[0] = 32'd1000;
      timeout_plan[1] = 32'd0;
      timeout_plan[2] = 32'hFFFF_FFFF;
      timeout_plan[3] = 32'd1;
      timeout_plan[4] = $urandom_range(100, 5000);
      timeout_plan[5] = TIMEOUT_RESET;

      //      op              id     ch   cnt code  payload       now                 typed status
      add_row(OP_READ,        5,     0,   0,  0,    32'h0,        64'd0,              1, ST_NO_ENTRY);
      add_row(OP_RECEIVE,     5,     0,   0,  1,    32'h1234,     64'd10,             1, ST_NO_ENTRY);
      add_row(OP_UNSUBSCRIBE, 5,     0,   0,  0,    32'h0,        64'd0,              1, ST_NO_ENTRY);
      add_row(OP_SUBSCRIBE,   'h7FF, 0,   0,  0,    32'h0,        64'd0,              1, ST_BAD_CHANNEL);
      add_row(OP_SUBSCRIBE,   0,     0,   5,  0,    32'h0,        64'd0,              1, ST_BAD_CHANNEL);
      add_row(OP_SUBSCRIBE,   'h7FF, 0,   4,  0,    32'h0,        64'd0,              1, ST_OK);
      add_row(OP_SUBSCRIBE,   'h7FF, 0,   1,  0,    32'h0,        64'd0,              1, ST_EXISTS);
      add_row(OP_SUBSCRIBE,   0,     0,   1,  0,    32'h0,        64'd0,              1, ST_OK);
      add_row(OP_RECEIVE,     0,     1,   0,  3,    32'h55,       64'd5,              1, ST_BAD_CHANNEL);
      add_row(OP_RECEIVE,     'h7FF, 255, 0,  3,    32'h55,       64'd5,              1, ST_BAD_CHANNEL);
      add_row(OP_READ,        'h7FF, 3,   0,  0,    32'h0,        64'd0,              1, ST_OK);
      // timestamp zero leaves the channel looking unused
      add_row(OP_RECEIVE,     'h7FF, 0,   0,  10,   32'h0,        64'd0,              0, ST_OK);
      add_row(OP_RECEIVE,     'h7FF, 0,   0,  10,   32'hA1B2C3D4, 64'd100,            0, ST_OK);
      add_row(OP_RECEIVE,     'h7FF, 0,   0,  10,   32'h11111111, 64'd200,            1, ST_REPEAT);
      add_row(OP_RECEIVE,     'h7FF, 0,   0,  11,   32'h22222222, 64'd300,            0, ST_OK);
      add_row(OP_RECEIVE,     'h7FF, 0,   0,  138,  32'h33333333, 64'd400,            1, ST_REPEAT);
      add_row(OP_RECEIVE,     'h7FF, 0,   0,  137,  32'h44444444, 64'd500,            0, ST_OK);
      add_row(OP_RECEIVE,     'h7FF, 0,   0,  9,    32'h55555555, 64'd600,            0, ST_OK);
      add_row(OP_RECEIVE,     'h7FF, 0,   0,  8,    32'h66666666, 64'd700,            1, ST_REPEAT);
      // earlier timestamp wraps to a large age
      add_row(OP_RECEIVE,     'h7FF, 0,   0,  8,    32'h77777777, 64'd50,             0, ST_OK);
      add_row(OP_RECEIVE,     'h7FF, 0,   0,  8,    32'h88888888, 64'd30_000_050,     0, ST_OK);
      add_row(OP_RECEIVE,     'h7FF, 0,   0,  8,    32'h99999999, 64'd60_000_049,     1, ST_REPEAT);
      add_row(OP_READ,        'h7FF, 0,   0,  0,    32'h0,        64'd0,              0, ST_OK);
      add_row(OP_RECEIVE,     'h7FF, 3,   0,  255,  32'hFFFFFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 0, ST_OK);
      add_row(OP_READ,        'h7FF, 3,   0,  0,    32'h0,        64'd0,              0, ST_OK);
      add_row(OP_UNSUBSCRIBE, 'h7FF, 0,   0,  0,    32'h0,        64'd0,              1, ST_OK);
      add_row(OP_READ,        'h7FF, 0,   0,  0,    32'h0,        64'd0,              1, ST_NO_ENTRY);

      idle_pct = 25;
      stall_pct = 45;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].result);

      for (int p = 0; p < PHASES; p++) begin
         write_timeout(timeout_plan[p]);
         idle_pct = (p < 2) ? 25 : (p < 4) ? 45 : 0;
         stall_pct = (p < 2) ? 45 : (p < 4) ? 25 : 0;
         repeat (PHASE_SIZE) send_word(random_word(), 1'b0, '0);
      end

      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      $display("sent %0d words across %0d repeat timeouts and three idling mixes",
               words_sent, PHASES + 1);
      $display("checked %0d results: %0d delivered, %0d repeats dropped, %0d table full",
               results_checked, delivered_seen, repeats_seen, full_seen);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/core/psrf_pkg.sv
rtl/core/psrf_ram.sv
rtl/core/param_subscription_repeat_filter.sv
test/param_subscription_repeat_filter_test.sv
